FILE: rtl/sst_pkg.sv
package sst_pkg;

   localparam int CLASS_DEPTH = 64;
   localparam int SUB_DEPTH   = 64;
   localparam int KEY_BITS    = 64;

   localparam int MAX_DEPTH = (CLASS_DEPTH > SUB_DEPTH) ? CLASS_DEPTH : SUB_DEPTH;
   localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
   localparam int CLS_AW    = $clog2(CLASS_DEPTH);
   localparam int SUB_AW    = $clog2(SUB_DEPTH);

   localparam int REQ_DATA_W = 128;
   localparam int REQ_USER_W = 4;
   localparam int RSP_DATA_W = 104;
   localparam int RSP_USER_W = 5;

   localparam logic [1:0] FUNC_DEFINE = 2'd0;
   localparam logic [1:0] FUNC_NEWSUB = 2'd1;
   localparam logic [1:0] FUNC_LOOKUP = 2'd2;
   localparam logic [1:0] FUNC_CLEAR  = 2'd3;

   localparam logic [2:0] KIND_STATIC = 3'd0;
   localparam logic [2:0] KIND_FIELD  = 3'd1;
   localparam logic [2:0] KIND_ARG    = 3'd2;
   localparam logic [2:0] KIND_LOCAL  = 3'd3;
   localparam logic [2:0] KIND_NONE   = 3'd4;

   typedef struct packed {
      logic [KEY_BITS-1:0] name;
      logic [KEY_BITS-1:0] sym_type;
      logic                flag;
      logic [5:0]          index;
   } row_type;

   localparam int ROW_W = $bits(row_type);

   function automatic logic [6:0] cnt7(input logic [CNT_W-1:0] c);
      logic [CNT_W+6:0] w;
      w = {7'b0, c};
      return w[6:0];
   endfunction

   function automatic logic [5:0] idx6(input logic [CNT_W-1:0] c);
      logic [CNT_W+5:0] w;
      w = {6'b0, c};
      return w[5:0];
   endfunction

endpackage

FILE: rtl/scoped_symbol_table.sv
// Define, new-subroutine and clear: the item passes the execute state, and the done state registers the result.
// Lookup: scans the subroutine rows, then the class rows, until a hit or the end;
// one RAM read and one key compare per cycle.
// One item in flight; the next is taken the cycle after the result is registered,
// also while that result waits.
// Synchronous active-high reset zeroes the kind counts; table rows need no clearing.
module scoped_symbol_table
   import sst_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // name_key, type_key
   input  logic [REQ_USER_W-1:0] req_tuser,  // func, sym_kind
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // found_type, found_index, count_static,
                                             // count_field, count_arg, count_var, pad
   output logic [RSP_USER_W-1:0] rsp_tuser   // found, found_kind, full_error
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_SUB  = 3'd2;
   localparam logic [2:0] ST_CLS  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   localparam logic [CNT_W-1:0] CLASS_FULL = CNT_W'(CLASS_DEPTH);
   localparam logic [CNT_W-1:0] SUB_FULL   = CNT_W'(SUB_DEPTH);

   logic [2:0]          state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff [4];
   logic [CNT_W-1:0]    cnt_in [4];
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic                chk_ff, chk_in;

   logic [1:0]          func_ff, func_in;
   logic [1:0]          kind_ff, kind_in;
   logic [KEY_BITS-1:0] name_ff, name_in;
   logic [KEY_BITS-1:0] type_ff, type_in;

   logic                res_found_ff, res_found_in;
   logic [2:0]          res_kind_ff, res_kind_in;
   logic [KEY_BITS-1:0] res_type_ff, res_type_in;
   logic [5:0]          res_index_ff, res_index_in;
   logic                res_full_ff, res_full_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   logic [CNT_W-1:0] fill_c, fill_s;
   row_type          wr_row, cls_row, sub_row, scan_row;
   logic             cls_wr, sub_wr, cls_rd, sub_rd;
   logic [ROW_W-1:0] cls_rd_data, sub_rd_data;
   logic             hit;

   assign fill_c = cnt_ff[0] + cnt_ff[1];
   assign fill_s = cnt_ff[2] + cnt_ff[3];

   assign wr_row.name     = name_ff;
   assign wr_row.sym_type = type_ff;
   assign wr_row.flag     = kind_ff[0];
   assign wr_row.index    = idx6(cnt_ff[kind_ff]);

   assign cls_row  = row_type'(cls_rd_data);
   assign sub_row  = row_type'(sub_rd_data);
   assign scan_row = (state_ff == ST_SUB) ? sub_row : cls_row;
   assign hit      = chk_ff && (scan_row.name == name_ff);

   sst_ram #(.DEPTH(CLASS_DEPTH), .WIDTH(ROW_W)) u_class_ram (
      .clock   (clock),
      .wr_en   (cls_wr),
      .wr_addr (fill_c[CLS_AW-1:0]),
      .wr_data (wr_row),
      .rd_en   (cls_rd),
      .rd_addr (idx_ff[CLS_AW-1:0]),
      .rd_data (cls_rd_data)
   );

   sst_ram #(.DEPTH(SUB_DEPTH), .WIDTH(ROW_W)) u_sub_ram (
      .clock   (clock),
      .wr_en   (sub_wr),
      .wr_addr (fill_s[SUB_AW-1:0]),
      .wr_data (wr_row),
      .rd_en   (sub_rd),
      .rd_addr (idx_ff[SUB_AW-1:0]),
      .rd_data (sub_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      chk_in       = 1'b0;
      func_in      = func_ff;
      kind_in      = kind_ff;
      name_in      = name_ff;
      type_in      = type_ff;
      res_found_in = res_found_ff;
      res_kind_in  = res_kind_ff;
      res_type_in  = res_type_ff;
      res_index_in = res_index_ff;
      res_full_in  = res_full_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      cls_wr       = 1'b0;
      sub_wr       = 1'b0;
      cls_rd       = 1'b0;
      sub_rd       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               func_in      = req_tuser[1:0];
               kind_in      = req_tuser[3:2];
               name_in      = req_tdata[KEY_BITS-1:0];
               type_in      = req_tdata[64 +: KEY_BITS];
               res_found_in = 1'b0;
               res_kind_in  = KIND_NONE;
               res_type_in  = '0;
               res_index_in = '0;
               res_full_in  = 1'b0;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            case (func_ff)
               FUNC_DEFINE: begin
                  if (!kind_ff[1]) begin
                     if (fill_c >= CLASS_FULL) begin
                        res_full_in = 1'b1;
                     end else begin
                        cls_wr           = 1'b1;
                        cnt_in[kind_ff]  = cnt_ff[kind_ff] + CNT_W'(1);
                     end
                  end else begin
                     if (fill_s >= SUB_FULL) begin
                        res_full_in = 1'b1;
                     end else begin
                        sub_wr           = 1'b1;
                        cnt_in[kind_ff]  = cnt_ff[kind_ff] + CNT_W'(1);
                     end
                  end
               end
               FUNC_NEWSUB: begin
                  cnt_in[2] = '0;
                  cnt_in[3] = '0;
               end
               FUNC_LOOKUP: begin
                  if (name_ff != '0) begin
                     idx_in   = '0;
                     state_in = ST_SUB;
                  end
               end
               default: begin
                  cnt_in[0] = '0;
                  cnt_in[1] = '0;
                  cnt_in[2] = '0;
                  cnt_in[3] = '0;
               end
            endcase
         end
         ST_SUB: begin
            if (hit) begin
               res_found_in = 1'b1;
               res_kind_in  = sub_row.flag ? KIND_LOCAL : KIND_ARG;
               res_type_in  = sub_row.sym_type;
               res_index_in = sub_row.index;
               state_in     = ST_DONE;
            end else if (idx_ff < fill_s) begin
               sub_rd = 1'b1;
               idx_in = idx_ff + CNT_W'(1);
               chk_in = 1'b1;
            end else begin
               idx_in   = '0;
               state_in = ST_CLS;
            end
         end
         ST_CLS: begin
            if (hit) begin
               res_found_in = 1'b1;
               res_kind_in  = cls_row.flag ? KIND_FIELD : KIND_STATIC;
               res_type_in  = cls_row.sym_type;
               res_index_in = cls_row.index;
               state_in     = ST_DONE;
            end else if (idx_ff < fill_c) begin
               cls_rd = 1'b1;
               idx_in = idx_ff + CNT_W'(1);
               chk_in = 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'b0, cnt7(cnt_ff[3]), cnt7(cnt_ff[2]), cnt7(cnt_ff[1]),
                               cnt7(cnt_ff[0]), res_index_ff, 64'(res_type_ff)};
               rsp_user_in  = {res_full_ff, res_kind_ff, res_found_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '{default: '0};
         idx_ff       <= '0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff      <= func_in;
      kind_ff      <= kind_in;
      name_ff      <= name_in;
      type_ff      <= type_in;
      res_found_ff <= res_found_in;
      res_kind_ff  <= res_kind_in;
      res_type_ff  <= res_type_in;
      res_index_ff <= res_index_in;
      res_full_ff  <= res_full_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

FILE: rtl/sst_ram.sv
module sst_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sim/scoped_symbol_table_checker.sv
module scoped_symbol_table_checker
   import sst_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic [RSP_USER_W-1:0] rsp_tuser,
   output int                    fail_count,
   output int                    outstanding,
   output int                    lookup_count,
   output int                    hit_count,
   output int                    drop_count
);

   typedef struct packed {
      logic                found;
      logic [2:0]          kind;
      logic [KEY_BITS-1:0] sym_type;
      logic [5:0]          index;
      logic [3:0][6:0]     counts;  // [0] static, [1] field, [2] arg, [3] local
      logic                full;
   } answer_type;

   logic [KEY_BITS-1:0] cls_name [CLASS_DEPTH];
   logic [KEY_BITS-1:0] cls_type [CLASS_DEPTH];
   logic                cls_field [CLASS_DEPTH];
   logic [5:0]          cls_idx [CLASS_DEPTH];
   logic [KEY_BITS-1:0] sub_name [SUB_DEPTH];
   logic [KEY_BITS-1:0] sub_type [SUB_DEPTH];
   logic                sub_local [SUB_DEPTH];
   logic [5:0]          sub_idx [SUB_DEPTH];
   int                  kind_cnt [4];

   answer_type answers [$];
   int         n_fail = 0;
   int         n_wait = 0;
   int         n_lookup = 0;
   int         n_hit = 0;
   int         n_drop = 0;

   assign fail_count   = n_fail;
   assign outstanding  = n_wait;
   assign lookup_count = n_lookup;
   assign hit_count    = n_hit;
   assign drop_count   = n_drop;

   // Updates the table shadow and returns the result the item should produce.
   function automatic answer_type apply_op(logic [1:0] op, logic [KEY_BITS-1:0] name,
                                           logic [KEY_BITS-1:0] sym_type, logic [1:0] kind);
      answer_type a;
      int         fill;
      int         i;
      bit         done;
      a      = '0;
      a.kind = KIND_NONE;
      case (op)
         FUNC_DEFINE: begin
            if (kind < 2) begin
               fill = kind_cnt[0] + kind_cnt[1];
               if (fill >= CLASS_DEPTH) begin
                  a.full = 1'b1;
               end else begin
                  cls_name[fill]  = name;
                  cls_type[fill]  = sym_type;
                  cls_field[fill] = kind[0];
                  cls_idx[fill]   = 6'(kind_cnt[kind]);
                  kind_cnt[kind]++;
               end
            end else begin
               fill = kind_cnt[2] + kind_cnt[3];
               if (fill >= SUB_DEPTH) begin
                  a.full = 1'b1;
               end else begin
                  sub_name[fill]  = name;
                  sub_type[fill]  = sym_type;
                  sub_local[fill] = kind[0];
                  sub_idx[fill]   = 6'(kind_cnt[kind]);
                  kind_cnt[kind]++;
               end
            end
         end
         FUNC_NEWSUB: begin
            kind_cnt[2] = 0;
            kind_cnt[3] = 0;
         end
         FUNC_LOOKUP: begin
            done = 1'b0;
            if (name != '0) begin
               for (i = 0; i < kind_cnt[2] + kind_cnt[3] && !done; i++) begin
                  if (sub_name[i] == name) begin
                     a.found    = 1'b1;
                     a.kind     = sub_local[i] ? KIND_LOCAL : KIND_ARG;
                     a.sym_type = sub_type[i];
                     a.index    = sub_idx[i];
                     done       = 1'b1;
                  end
               end
               for (i = 0; i < kind_cnt[0] + kind_cnt[1] && !done; i++) begin
                  if (cls_name[i] == name) begin
                     a.found    = 1'b1;
                     a.kind     = cls_field[i] ? KIND_FIELD : KIND_STATIC;
                     a.sym_type = cls_type[i];
                     a.index    = cls_idx[i];
                     done       = 1'b1;
                  end
               end
            end
         end
         default: begin
            for (i = 0; i < 4; i++) kind_cnt[i] = 0;
         end
      endcase
      for (i = 0; i < 4; i++) a.counts[i] = 7'(kind_cnt[i]);
      return a;
   endfunction

   task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         n_fail++;
         $display("%0t mismatch on %s: expected %h actual %h", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      answer_type want;
      answer_type got;
      int         i;
      if (reset) begin
         for (i = 0; i < 4; i++) kind_cnt[i] = 0;
         answers.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.found    = rsp_tuser[0];
            got.kind     = rsp_tuser[3:1];
            got.full     = rsp_tuser[4];
            got.sym_type = rsp_tdata[63:0];
            got.index    = rsp_tdata[69:64];
            got.counts   = rsp_tdata[97:70];
            if (answers.size() == 0) begin
               n_fail++;
               $display("%0t unexpected item: expected none actual %h %h",
                        $time, rsp_tuser, rsp_tdata);
            end else begin
               want = answers.pop_front();
               check_field("found", 64'(want.found), 64'(got.found));
               check_field("found_kind", 64'(want.kind), 64'(got.kind));
               check_field("found_type", 64'(want.sym_type), 64'(got.sym_type));
               check_field("found_index", 64'(want.index), 64'(got.index));
               check_field("count_static", 64'(want.counts[0]), 64'(got.counts[0]));
               check_field("count_field", 64'(want.counts[1]), 64'(got.counts[1]));
               check_field("count_arg", 64'(want.counts[2]), 64'(got.counts[2]));
               check_field("count_var", 64'(want.counts[3]), 64'(got.counts[3]));
               check_field("full_error", 64'(want.full), 64'(got.full));
            end
         end
         if (req_tvalid && req_tready) begin
            want = apply_op(req_tuser[1:0], req_tdata[KEY_BITS-1:0],
                            req_tdata[64+KEY_BITS-1:64], req_tuser[3:2]);
            answers.push_back(want);
            if (req_tuser[1:0] == FUNC_LOOKUP) n_lookup++;
            if (want.found) n_hit++;
            if (want.full) n_drop++;
         end
      end
      n_wait = answers.size();
   end

endmodule

FILE: sim/scoped_symbol_table_tb.sv
module scoped_symbol_table_tb;
   import sst_pkg::*;

   localparam int ITEM_TARGET = 1000;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 300;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // name_key, type_key
   logic [REQ_USER_W-1:0] req_tuser = '0;  // func, sym_kind
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;       // found_type, found_index, counts x4, pad
   logic [RSP_USER_W-1:0] rsp_tuser;       // found, found_kind, full_error

   int fail_count;
   int outstanding;
   int lookup_count;
   int hit_count;
   int drop_count;

   int cycles = 0;
   int sent = 0;
   int burst_left = 0;
   bit hold_done = 1'b0;

   logic [63:0] name_pool [16];

   scoped_symbol_table uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   scoped_symbol_table_checker checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .fail_count   (fail_count),
      .outstanding  (outstanding),
      .lookup_count (lookup_count),
      .hit_count    (hit_count),
      .drop_count   (drop_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("status: fail");
         $finish;
      end
   end

   function automatic logic [63:0] rand_key();
      return {$urandom, $urandom};
   endfunction

   // mostly pooled names so lookups hit, some fresh keys, a few empty ones
   function automatic logic [63:0] pick_name();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return name_pool[$urandom_range(0, 15)];
      if (r < 94) return rand_key();
      return '0;
   endfunction

   task automatic offer(logic [1:0] op, logic [63:0] name, logic [63:0] sym_type,
                        logic [1:0] kind);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {sym_type, name};
      req_tuser  = {kind, op};
      burst_left--;
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   // push both scopes past their depth
   task automatic fill_scopes();
      int i;
      offer(FUNC_CLEAR, rand_key(), rand_key(), 2'($urandom_range(0, 3)));
      for (i = 0; i < CLASS_DEPTH + 3; i++)
         offer(FUNC_DEFINE, pick_name(), rand_key(),
               2'($urandom_range(KIND_STATIC, KIND_FIELD)));
      for (i = 0; i < 6; i++)
         offer(FUNC_LOOKUP, pick_name(), rand_key(), 2'($urandom_range(0, 3)));
      offer(FUNC_NEWSUB, rand_key(), rand_key(), 2'($urandom_range(0, 3)));
      for (i = 0; i < SUB_DEPTH + 3; i++)
         offer(FUNC_DEFINE, pick_name(), rand_key(),
               2'($urandom_range(KIND_ARG, KIND_LOCAL)));
      for (i = 0; i < 8; i++)
         offer(FUNC_LOOKUP, pick_name(), rand_key(), 2'($urandom_range(0, 3)));
   endtask

   // receiver: runs of varying readiness, plus one long hold-off
   initial begin
      int pct;
      int run;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!hold_done && sent >= 400) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            case ($urandom_range(0, 3))
               0: pct = 100;
               1: pct = 75;
               2: pct = 50;
               default: pct = 20;
            endcase
            run = $urandom_range(5, 60);
            repeat (run) begin
               rsp_tready = ($urandom_range(0, 99) < pct);
               @(negedge clock);
            end
         end
      end
   end

   initial begin
      logic [63:0] ones;
      int          i;
      int          n;
      int          r;
      bit          fill_a;
      bit          fill_b;
      ones   = '1;
      fill_a = 1'b0;
      fill_b = 1'b0;
      for (i = 0; i < 16; i++) begin
         do name_pool[i] = rand_key(); while (name_pool[i] == '0);
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed
      offer(FUNC_DEFINE, ones, ones, KIND_STATIC[1:0]);
      offer(FUNC_DEFINE, name_pool[0], '0, KIND_FIELD[1:0]);
      offer(FUNC_DEFINE, ones, 64'h5555_5555_5555_5555, KIND_ARG[1:0]);
      offer(FUNC_DEFINE, name_pool[1], 64'haaaa_aaaa_aaaa_aaaa, KIND_LOCAL[1:0]);
      offer(FUNC_DEFINE, '0, rand_key(), KIND_LOCAL[1:0]);
      offer(FUNC_DEFINE, name_pool[1], rand_key(), KIND_ARG[1:0]);
      offer(FUNC_LOOKUP, ones, rand_key(), KIND_STATIC[1:0]);
      offer(FUNC_LOOKUP, name_pool[1], rand_key(), KIND_LOCAL[1:0]);
      offer(FUNC_LOOKUP, name_pool[0], '0, KIND_ARG[1:0]);
      offer(FUNC_LOOKUP, '0, ones, KIND_FIELD[1:0]);
      offer(FUNC_LOOKUP, name_pool[2], rand_key(), KIND_STATIC[1:0]);
      offer(FUNC_NEWSUB, ones, ones, KIND_LOCAL[1:0]);
      offer(FUNC_LOOKUP, ones, '0, KIND_STATIC[1:0]);
      offer(FUNC_LOOKUP, name_pool[1], '0, KIND_STATIC[1:0]);
      offer(FUNC_DEFINE, '0, ones, KIND_STATIC[1:0]);
      offer(FUNC_CLEAR, ones, ones, KIND_LOCAL[1:0]);
      offer(FUNC_LOOKUP, name_pool[0], rand_key(), KIND_FIELD[1:0]);
      offer(FUNC_DEFINE, name_pool[0], rand_key(), KIND_FIELD[1:0]);
      offer(FUNC_LOOKUP, name_pool[0], rand_key(), KIND_LOCAL[1:0]);
      offer(FUNC_NEWSUB, rand_key(), rand_key(), KIND_ARG[1:0]);
      offer(FUNC_CLEAR, '0, '0, KIND_STATIC[1:0]);

      // random sequences
      while (sent < ITEM_TARGET) begin
         if (!fill_a && sent >= 150) begin
            fill_a = 1'b1;
            fill_scopes();
         end else if (!fill_b && sent >= 600) begin
            fill_b = 1'b1;
            fill_scopes();
         end
         r = $urandom_range(0, 99);
         if (r < 12) begin
            n = $urandom_range(1, 6);
            repeat (n) offer(FUNC_DEFINE, pick_name(), rand_key(),
                             2'($urandom_range(KIND_STATIC, KIND_FIELD)));
         end else if (r < 70) begin
            offer(FUNC_NEWSUB, rand_key(), rand_key(), 2'($urandom_range(0, 3)));
            n = $urandom_range(0, 4);
            repeat (n) offer(FUNC_DEFINE, pick_name(), rand_key(), KIND_ARG[1:0]);
            n = $urandom_range(0, 6);
            repeat (n) offer(FUNC_DEFINE, pick_name(), rand_key(), KIND_LOCAL[1:0]);
            n = $urandom_range(1, 10);
            repeat (n) offer(FUNC_LOOKUP, pick_name(), rand_key(), 2'($urandom_range(0, 3)));
         end else if (r < 80) begin
            n = $urandom_range(1, 8);
            repeat (n) offer(FUNC_LOOKUP, pick_name(), rand_key(), 2'($urandom_range(0, 3)));
         end else if (r < 85) begin
            offer(FUNC_CLEAR, rand_key(), rand_key(), 2'($urandom_range(0, 3)));
            n = $urandom_range(1, 8);
            repeat (n) offer(FUNC_DEFINE, pick_name(), rand_key(),
                             2'($urandom_range(KIND_STATIC, KIND_FIELD)));
         end else if (r < 98) begin
            n = $urandom_range(1, 5);
            repeat (n) offer(2'($urandom_range(0, 3)), pick_name(), rand_key(),
                             2'($urandom_range(0, 3)));
         end else begin
            fill_scopes();
         end
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (SUB_DEPTH + CLASS_DEPTH + 10) @(posedge clock);

      $display("covered %0d items: %0d lookups with %0d hits, %0d defines dropped on a full scope",
               sent, lookup_count, hit_count, drop_count);
      $display("long result hold-off %0s, %0d mismatches", hold_done ? "done" : "missed",
               fail_count);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: scoped_symbol_table.f
rtl/sst_pkg.sv
rtl/sst_ram.sv
rtl/scoped_symbol_table.sv
sim/scoped_symbol_table_checker.sv
sim/scoped_symbol_table_tb.sv
